@@ hw/rtl/ttad_pkg.sv @@
// Shared types and constants for the teletext attribute decoder.
// Holds the control-code values, the classified item passed from front to back and the op codes.
// Depends on nothing; every other file refers to it by scoped names.
package ttad_pkg;

  // Control codes, taken from the low five bits of a byte whose bit 7 is clear.
  localparam logic [4:0] CC_ALPHA_FIRST = 5'd1;
  localparam logic [4:0] CC_ALPHA_LAST  = 5'd7;
  localparam logic [4:0] CC_FLASH       = 5'd8;
  localparam logic [4:0] CC_STEADY      = 5'd9;
  localparam logic [4:0] CC_NORMAL_HT   = 5'd12;
  localparam logic [4:0] CC_DOUBLE_HT   = 5'd13;
  localparam logic [4:0] CC_GFX_FIRST   = 5'd17;
  localparam logic [4:0] CC_GFX_LAST    = 5'd23;
  localparam logic [4:0] CC_CONCEAL     = 5'd24;
  localparam logic [4:0] CC_CONTIG      = 5'd25;
  localparam logic [4:0] CC_SEPAR       = 5'd26;
  localparam logic [4:0] CC_BLACK_BG    = 5'd28;
  localparam logic [4:0] CC_NEW_BG      = 5'd29;

  // Printable range and glyph ROM layout.
  localparam logic [6:0] SPACE_CODE    = 7'h20;
  localparam logic [6:0] GFX_LOW_FIRST = 7'd64;
  localparam logic [6:0] GFX_MAP_FIRST = 7'd96;
  localparam logic [7:0] BASE_TEXT     = 8'd0;
  localparam logic [7:0] BASE_CONTIG   = 8'd96;
  localparam logic [7:0] BASE_SEPAR    = 8'd160;
  localparam logic [2:0] WHITE         = 3'd7;
  localparam logic [2:0] BLACK         = 3'd0;

  // Queue depth between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Attribute operation picked by the front for one byte.
  typedef enum logic [3:0] {
    OP_PRINT,
    OP_TEXT_COL,
    OP_GFX_COL,
    OP_FLASH,
    OP_STEADY,
    OP_NORMAL_HT,
    OP_DOUBLE_HT,
    OP_CONCEAL,
    OP_CONTIG,
    OP_SEPAR,
    OP_BLACK_BG,
    OP_NEW_BG
  } op_e;

  // Glyph set currently selected.
  typedef enum logic [1:0] {
    SET_TEXT,
    SET_CONTIG,
    SET_SEPAR
  } gset_e;

  // One classified byte as it waits in the queue.
  typedef struct packed {
    op_e        op;
    logic       inverse;
    logic [6:0] disp;
    logic       set_col;
    logic [2:0] colour;
    logic       row_start;
    logic       row_dbl;
    logic       flash_phase;
  } item_t;

endpackage

@@ hw/rtl/ttad_front.sv @@
// Front of the teletext attribute decoder: classifies each incoming byte.
// Produces a ttad_pkg::item_t with the attribute op, display code and colour load.
// Depends on ttad_pkg.
module ttad_front (
  input  logic [7:0]     char_code_i,
  input  logic           row_start_i,
  input  logic           row_has_double_i,
  input  logic           flash_phase_i,
  output ttad_pkg::item_t item_o
);

  logic       inv;
  logic [6:0] low7;
  ttad_pkg::op_e op;

  assign inv  = char_code_i[7];
  assign low7 = char_code_i[6:0];

  // Decode control codes; they only act while bit 7 is clear.
  always_comb begin
    op = ttad_pkg::OP_PRINT;
    if (!inv && (low7 < ttad_pkg::SPACE_CODE)) begin
      unique case (low7[4:0]) inside
        [ttad_pkg::CC_ALPHA_FIRST:ttad_pkg::CC_ALPHA_LAST]: op = ttad_pkg::OP_TEXT_COL;
        ttad_pkg::CC_FLASH:                               op = ttad_pkg::OP_FLASH;
        ttad_pkg::CC_STEADY:                              op = ttad_pkg::OP_STEADY;
        ttad_pkg::CC_NORMAL_HT:                           op = ttad_pkg::OP_NORMAL_HT;
        ttad_pkg::CC_DOUBLE_HT:                           op = ttad_pkg::OP_DOUBLE_HT;
        [ttad_pkg::CC_GFX_FIRST:ttad_pkg::CC_GFX_LAST]:   op = ttad_pkg::OP_GFX_COL;
        ttad_pkg::CC_CONCEAL:                             op = ttad_pkg::OP_CONCEAL;
        ttad_pkg::CC_CONTIG:                              op = ttad_pkg::OP_CONTIG;
        ttad_pkg::CC_SEPAR:                               op = ttad_pkg::OP_SEPAR;
        ttad_pkg::CC_BLACK_BG:                            op = ttad_pkg::OP_BLACK_BG;
        ttad_pkg::CC_NEW_BG:                              op = ttad_pkg::OP_NEW_BG;
        default:                                          op = ttad_pkg::OP_PRINT;
      endcase
    end
  end

  // Assemble the item. Anything below a space displays as a space, and an inverse
  // byte whose low seven bits are a colour value still loads the text colour.
  always_comb begin
    item_o.op          = op;
    item_o.inverse     = inv;
    item_o.disp        = (low7 < ttad_pkg::SPACE_CODE) ? ttad_pkg::SPACE_CODE : low7;
    item_o.set_col     = (op == ttad_pkg::OP_TEXT_COL) || (op == ttad_pkg::OP_GFX_COL) ||
                         (inv && (low7 <= 7'd7));
    item_o.colour      = char_code_i[2:0];
    item_o.row_start   = row_start_i;
    item_o.row_dbl     = row_has_double_i;
    item_o.flash_phase = flash_phase_i;
  end

endmodule

@@ hw/rtl/ttad_queue.sv @@
// Short queue between the front and the back of the teletext attribute decoder.
// Holds classified items so that each side can stall on its own.
// Depends on ttad_pkg.
module ttad_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ttad_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            avail_o,
  output ttad_pkg::item_t head_o
);

  ttad_pkg::item_t                     mem_q [ttad_pkg::QUEUE_DEPTH];
  logic [ttad_pkg::QPTR_W-1:0]         wr_ptr_q, wr_ptr_d;
  logic [ttad_pkg::QPTR_W-1:0]         rd_ptr_q, rd_ptr_d;
  logic [ttad_pkg::QCNT_W-1:0]         count_q, count_d;

  assign full_o  = (count_q == ttad_pkg::QCNT_W'(ttad_pkg::QUEUE_DEPTH));
  assign avail_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update; a beat may enter while another leaves in the same cycle.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == ttad_pkg::QPTR_W'(ttad_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == ttad_pkg::QPTR_W'(ttad_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset; entries are only read once written.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ hw/rtl/ttad_back.sv @@
// Back of the teletext attribute decoder: keeps the serial attribute state.
// Applies each queued item to the state and registers glyph index, colours and height flag.
// Depends on ttad_pkg.
module ttad_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            avail_i,
  input  ttad_pkg::item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      glyph_index_o,
  output logic [2:0]      fore_colour_o,
  output logic [2:0]      back_colour_o,
  output logic            tall_flag_o
);

  // Attribute state.
  logic [2:0]      text_col_q, text_col_d;
  logic [2:0]      back_col_q, back_col_d;
  ttad_pkg::gset_e gset_q, gset_d;
  logic            sep_q, sep_d;
  logic            dbl_q, dbl_d;
  logic            conceal_q, conceal_d;
  logic            flash_q, flash_d;

  // Output register.
  logic       out_valid_q;
  logic [7:0] glyph_q, glyph_d;
  logic [2:0] fg_q, fg_d;
  logic [2:0] bg_q, bg_d;
  logic       tall_q;

  // State as seen after the row start reset.
  logic [2:0]      cur_text, cur_back;
  ttad_pkg::gset_e cur_gset;
  logic            cur_sep, cur_dbl, cur_conceal, cur_flash;

  logic [6:0] code;
  logic [7:0] base;

  assign pop_o = avail_i && (!out_valid_q || out_ready_i);

  // Row start loads the reset state before the byte acts.
  always_comb begin
    if (item_i.row_start) begin
      cur_text    = ttad_pkg::WHITE;
      cur_back    = ttad_pkg::BLACK;
      cur_gset    = ttad_pkg::SET_TEXT;
      cur_sep     = 1'b0;
      cur_dbl     = item_i.row_dbl;
      cur_conceal = 1'b0;
      cur_flash   = 1'b0;
    end else begin
      cur_text    = text_col_q;
      cur_back    = back_col_q;
      cur_gset    = gset_q;
      cur_sep     = sep_q;
      cur_dbl     = dbl_q;
      cur_conceal = conceal_q;
      cur_flash   = flash_q;
    end
  end

  // Apply the attribute op.
  always_comb begin
    back_col_d = cur_back;
    gset_d     = cur_gset;
    sep_d      = cur_sep;
    dbl_d      = cur_dbl;
    conceal_d  = cur_conceal;
    flash_d    = cur_flash;
    unique case (item_i.op)
      ttad_pkg::OP_PRINT:     ;
      ttad_pkg::OP_TEXT_COL:  gset_d = ttad_pkg::SET_TEXT;
      ttad_pkg::OP_GFX_COL:   gset_d = cur_sep ? ttad_pkg::SET_SEPAR : ttad_pkg::SET_CONTIG;
      ttad_pkg::OP_FLASH:     flash_d = 1'b1;
      ttad_pkg::OP_STEADY:    flash_d = 1'b0;
      ttad_pkg::OP_NORMAL_HT: dbl_d = 1'b0;
      ttad_pkg::OP_DOUBLE_HT: dbl_d = 1'b1;
      ttad_pkg::OP_CONCEAL:   conceal_d = 1'b1;
      ttad_pkg::OP_CONTIG: begin
        sep_d = 1'b0;
        if (cur_gset != ttad_pkg::SET_TEXT) gset_d = ttad_pkg::SET_CONTIG;
      end
      ttad_pkg::OP_SEPAR: begin
        sep_d = 1'b1;
        if (cur_gset != ttad_pkg::SET_TEXT) gset_d = ttad_pkg::SET_SEPAR;
      end
      ttad_pkg::OP_BLACK_BG:  back_col_d = ttad_pkg::BLACK;
      ttad_pkg::OP_NEW_BG:    back_col_d = cur_text;
      default:                ;
    endcase
    // A colour code takes effect from the next cell.
    text_col_d = item_i.set_col ? item_i.colour : cur_text;
  end

  // Colours: the background change shows on its own cell, the text colour does not.
  always_comb begin
    fg_d = item_i.inverse ? ~cur_text   : cur_text;
    bg_d = item_i.inverse ? ~back_col_d : back_col_d;
  end

  // Glyph index: conceal, graphics remapping, then flash blanking.
  always_comb begin
    code = conceal_d ? ttad_pkg::SPACE_CODE : item_i.disp;
    unique case (gset_d)
      ttad_pkg::SET_CONTIG: base = ttad_pkg::BASE_CONTIG;
      ttad_pkg::SET_SEPAR:  base = ttad_pkg::BASE_SEPAR;
      default:              base = ttad_pkg::BASE_TEXT;
    endcase
    if (gset_d != ttad_pkg::SET_TEXT) begin
      if (code >= ttad_pkg::GFX_MAP_FIRST) begin
        code = code - 7'd32;
      end else if (code >= ttad_pkg::GFX_LOW_FIRST) begin
        base = ttad_pkg::BASE_TEXT;
      end
    end
    if (flash_d && item_i.flash_phase) begin
      code = ttad_pkg::SPACE_CODE;
    end
    glyph_d = {1'b0, code} - {1'b0, ttad_pkg::SPACE_CODE} + base;
  end

  // Control and attribute state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      text_col_q  <= ttad_pkg::WHITE;
      back_col_q  <= ttad_pkg::BLACK;
      gset_q      <= ttad_pkg::SET_TEXT;
      sep_q       <= 1'b0;
      dbl_q       <= 1'b0;
      conceal_q   <= 1'b0;
      flash_q     <= 1'b0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        text_col_q  <= text_col_d;
        back_col_q  <= back_col_d;
        gset_q      <= gset_d;
        sep_q       <= sep_d;
        dbl_q       <= dbl_d;
        conceal_q   <= conceal_d;
        flash_q     <= flash_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      glyph_q <= glyph_d;
      fg_q    <= fg_d;
      bg_q    <= bg_d;
      tall_q  <= dbl_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign glyph_index_o = glyph_q;
  assign fore_colour_o = fg_q;
  assign back_colour_o = bg_q;
  assign tall_flag_o   = tall_q;

endmodule

@@ hw/rtl/teletext_attribute_decoder.sv @@
// Teletext attribute decoder, top level: one character byte in, one glyph beat out.
// A beat accepted into the queue waits there until the back stage pops it and registers the
// result. Throughput: one beat per cycle unless the output stalls, set by the single attribute
// update in the back stage. Input ready depends only on the two-entry queue having room.
// Reset (asynchronous, active low) empties the queue and output register and loads the
// row reset attributes: white text, black background, text glyphs, all modes off.
module teletext_attribute_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       row_start_i,
  input  logic       row_has_double_i,
  input  logic       flash_phase_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] glyph_index_o,
  output logic [2:0] fore_colour_o,
  output logic [2:0] back_colour_o,
  output logic       tall_flag_o
);

  ttad_pkg::item_t front_item;
  ttad_pkg::item_t head_item;
  logic            q_full;
  logic            q_avail;
  logic            q_pop;

  assign in_ready_o = !q_full;

  // Classify the byte.
  ttad_front u_front (
    .char_code_i      (char_code_i),
    .row_start_i      (row_start_i),
    .row_has_double_i (row_has_double_i),
    .flash_phase_i    (flash_phase_i),
    .item_o           (front_item)
  );

  // Decouple front and back.
  ttad_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && !q_full),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .avail_o     (q_avail),
    .head_o      (head_item)
  );

  // Apply attributes and drive the result.
  ttad_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .avail_i       (q_avail),
    .item_i        (head_item),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .glyph_index_o (glyph_index_o),
    .fore_colour_o (fore_colour_o),
    .back_colour_o (back_colour_o),
    .tall_flag_o   (tall_flag_o)
  );

endmodule
